// File: rtl/tile_dirty_rectangle_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tile dirty rectangle detector
// Shared property wrappers, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef TILE_DIRTY_RECTANGLE_DETECTOR_UNIT_ASSERT_SVH
`define TILE_DIRTY_RECTANGLE_DETECTOR_UNIT_ASSERT_SVH

// Plain property that must hold at every clock edge outside reset.
`define TDRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication outside reset.
`define TDRD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define TDRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tdrd_pkg.sv
// ----------------------------------------------------------------------------
// tdrd_pkg
// Types and constants shared by the tile dirty rectangle detector modules.
// ----------------------------------------------------------------------------
package tdrd_pkg;

    // Tile geometry and word size.
    localparam int unsigned MAX_TILE_DIM  = 64;
    localparam int unsigned WORD_BITS     = 32;
    localparam int unsigned DIM_W         = 7;
    localparam int unsigned POS_W         = 6;
    localparam int unsigned TILE_DIM_RST  = 64;

    // Stream and configuration port widths.
    localparam int unsigned FIELD_W       = 32;
    localparam int unsigned IN_TDATA_W    = 64;
    localparam int unsigned OUT_TDATA_W   = 32;
    localparam int unsigned CFG_IDX_W     = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_WIDTH  = 2'd0,
        REG_TILE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Effective tile size, both dimensions in 1..MAX_TILE_DIM.
    typedef struct packed {
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } tile_size_t;

    // One result; changed sits in the lowest bit when packed.
    typedef struct packed {
        logic [POS_W-1:0] bottom;
        logic [POS_W-1:0] right;
        logic [POS_W-1:0] top;
        logic [POS_W-1:0] left;
        logic             changed;
    } tile_box_t;

    localparam int unsigned BOX_W = $bits(tile_box_t);

    // Zero counts as one, anything above the maximum saturates.
    function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_TILE_DIM)) begin
            r = DIM_W'(MAX_TILE_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/tdrd_cfg.sv
// ----------------------------------------------------------------------------
// tdrd_cfg
// Tile size registers. Writes are clamped to the legal range as they land.
// ----------------------------------------------------------------------------
`include "tile_dirty_rectangle_detector_unit_assert.svh"

module tdrd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [tdrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdrd_pkg::DIM_W-1:0]     cfg_wdata,
    output tdrd_pkg::tile_size_t           size_o
);
    import tdrd_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Register writes; an index past the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(TILE_DIM_RST);
            height_reg <= DIM_W'(TILE_DIM_RST);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TILE_WIDTH: begin
                    width_reg <= eff_size(cfg_wdata);
                end
                REG_TILE_HEIGHT: begin
                    height_reg <= eff_size(cfg_wdata);
                end
                default: begin
                end
            endcase
        end
    end

    assign size_o.width  = width_reg;
    assign size_o.height = height_reg;

endmodule

// File: rtl/tdrd_tracker.sv
// ----------------------------------------------------------------------------
// tdrd_tracker
// Input register, word compare, raster position counters and bounding box.
// ----------------------------------------------------------------------------
`include "tile_dirty_rectangle_detector_unit_assert.svh"

module tdrd_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tdrd_pkg::IN_TDATA_W-1:0] s_tdata,
    input  tdrd_pkg::tile_size_t            size_i,
    input  logic                            out_full_i,
    output logic                            push_o,
    output tdrd_pkg::tile_box_t             box_o
);
    import tdrd_pkg::*;

    // Input register.
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [FIELD_W-1:0] new_reg;
    logic [FIELD_W-1:0] old_reg;

    // Tile state.
    logic [POS_W-1:0] col_reg,   col_next;
    logic [POS_W-1:0] row_reg,   row_next;
    logic             any_reg,   any_next;
    logic [POS_W-1:0] min_reg,   min_next;
    logic [POS_W-1:0] max_reg,   max_next;
    logic [POS_W-1:0] first_reg, first_next;
    logic [POS_W-1:0] last_reg,  last_next;

    // Box after this word, before the end-of-tile clear.
    logic             any_upd;
    logic [POS_W-1:0] min_upd;
    logic [POS_W-1:0] max_upd;
    logic [POS_W-1:0] first_upd;
    logic [POS_W-1:0] last_upd;

    logic             in_take;
    logic             advance;
    logic             diff;
    logic             row_end;
    logic             tile_end;
    logic [DIM_W-1:0] col_plus;
    logic [DIM_W-1:0] row_plus;

    // Position of this word relative to the tile edges.
    assign col_plus = {1'b0, col_reg} + DIM_W'(1);
    assign row_plus = {1'b0, row_reg} + DIM_W'(1);
    assign row_end  = (col_plus >= size_i.width);
    assign tile_end = row_end && (row_plus >= size_i.height);
    assign diff     = (new_reg[WORD_BITS-1:0] != old_reg[WORD_BITS-1:0]);

    // The held word moves on unless it ends a tile and the output is full.
    assign advance  = s1_valid_reg && !(tile_end && out_full_i);
    assign s_tready = !s1_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign push_o   = advance && tile_end;

    assign s1_valid_next = in_take || (s1_valid_reg && !advance);

    // Fold a differing word into the box.
    always_comb begin
        any_upd   = any_reg;
        min_upd   = min_reg;
        max_upd   = max_reg;
        first_upd = first_reg;
        last_upd  = last_reg;
        if (diff) begin
            if (!any_reg) begin
                any_upd   = 1'b1;
                min_upd   = col_reg;
                max_upd   = col_reg;
                first_upd = row_reg;
            end else begin
                if (col_reg < min_reg) begin
                    min_upd = col_reg;
                end
                if (col_reg > max_reg) begin
                    max_upd = col_reg;
                end
            end
            last_upd = row_reg;
        end
    end

    // Result of a finished tile; an unchanged tile reports an empty box.
    always_comb begin
        box_o.changed = any_upd;
        box_o.left    = any_upd ? min_upd   : '0;
        box_o.top     = any_upd ? first_upd : '0;
        box_o.right   = any_upd ? max_upd   : '0;
        box_o.bottom  = any_upd ? last_upd  : '0;
    end

    // Next state: step the raster position, or clear at the end of a tile.
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        any_next   = any_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        first_next = first_reg;
        last_next  = last_reg;
        if (advance) begin
            if (tile_end) begin
                col_next   = '0;
                row_next   = '0;
                any_next   = 1'b0;
                min_next   = '0;
                max_next   = '0;
                first_next = '0;
                last_next  = '0;
            end else begin
                any_next   = any_upd;
                min_next   = min_upd;
                max_next   = max_upd;
                first_next = first_upd;
                last_next  = last_upd;
                if (row_end) begin
                    col_next = '0;
                    row_next = row_plus[POS_W-1:0];
                end else begin
                    col_next = col_plus[POS_W-1:0];
                end
            end
        end
    end

    // Control and tile state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            any_reg      <= 1'b0;
            min_reg      <= '0;
            max_reg      <= '0;
            first_reg    <= '0;
            last_reg     <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            any_reg      <= any_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            first_reg    <= first_next;
            last_reg     <= last_next;
        end
    end

    // Word pair payload.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            new_reg <= s_tdata[FIELD_W-1:0];
            old_reg <= s_tdata[IN_TDATA_W-1:FIELD_W];
        end
    end

    // An empty box stays all zero until the first differing word.
    `TDRD_ASSERT_IMPL(a_empty_box_zero, !any_reg,
        (min_reg == '0) && (max_reg == '0) && (first_reg == '0) && (last_reg == '0),
        "box registers hold stale values while no difference is recorded")
    // The box is never inverted.
    `TDRD_ASSERT_IMPL(a_box_ordered, any_reg,
        (min_reg <= max_reg) && (first_reg <= last_reg),
        "bounding box edges out of order")
    // Emitting a tile restarts the raster position.
    `TDRD_ASSERT_NEXT(a_tile_restart, push_o,
        (col_reg == '0) && (row_reg == '0) && !any_reg,
        "tile state not cleared after a result")

endmodule

// File: rtl/tdrd_out_fifo.sv
// ----------------------------------------------------------------------------
// tdrd_out_fifo
// Two-entry result buffer that decouples the result side from the tracker.
// ----------------------------------------------------------------------------
`include "tile_dirty_rectangle_detector_unit_assert.svh"

module tdrd_out_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push_i,
    input  tdrd_pkg::tile_box_t              box_i,
    output logic                             full_o,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tdrd_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tdrd_pkg::*;

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tile_box_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign full_o   = (count_reg == CNT_W'(DEPTH));
    assign m_tdata  = {{(OUT_TDATA_W - BOX_W){1'b0}}, entry_reg[rd_ptr_reg]};

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_i) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_i && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push_i) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge aclk) begin
        if (push_i) begin
            entry_reg[wr_ptr_reg] <= box_i;
        end
    end

    // The fill level never passes the depth.
    `TDRD_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH),
        "result buffer fill level out of range")
    // The tracker holds its result while the buffer is full.
    `TDRD_ASSERT_IMPL(a_no_push_full, push_i, !full_o,
        "result written into a full buffer")

endmodule

// File: rtl/tile_dirty_rectangle_detector_unit.sv
// ----------------------------------------------------------------------------
// tile_dirty_rectangle_detector_unit
// Bounding box of the differing words between two frames over one tile.
// ----------------------------------------------------------------------------
// Word pairs (new frame, previous frame) stream in raster order over a tile
// of tile_width by tile_height words, and one pair is taken every clock
// cycle while s_tready is high. After the last word of a tile the block
// delivers one result, the changed flag and the box of differing words
// relative to the tile, and then starts the next tile. Each word passes
// through an input register and then the compare and min/max
// logic; results wait in a two-entry buffer, so input is held off only when
// a word ends a tile while that buffer is full. Tile size writes are clamped
// to 1..64; the position counters are kept across a size change.
// ----------------------------------------------------------------------------
module tile_dirty_rectangle_detector_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration writes.
    input  logic                             cfg_we,
    input  logic [tdrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdrd_pkg::DIM_W-1:0]       cfg_wdata,
    // Word pair requests.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: new_word [31:0], old_word [63:32].
    input  logic [tdrd_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Tile results.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: changed [0], box_left [6:1], box_top [12:7], box_right [18:13],
    //          box_bottom [24:19], zero [31:25].
    output logic [tdrd_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tdrd_pkg::*;

    tile_size_t size;
    tile_box_t  box;
    logic       push;
    logic       out_full;

    // Tile size registers.
    tdrd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .size_o    (size)
    );

    // Compare and box tracking.
    tdrd_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .size_i     (size),
        .out_full_i (out_full),
        .push_o     (push),
        .box_o      (box)
    );

    // Result buffer.
    tdrd_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_i   (push),
        .box_i    (box),
        .full_o   (out_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: tb/tile_dirty_rectangle_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for tile_dirty_rectangle_detector_unit
// Streams word pairs over tiles of many sizes and checks each box against a
// predictor that runs inside the bench. It covers the tile size registers
// (including zero and oversize writes), resizing in mid tile, random
// idle cycles on both sides, a long output hold-off and a steady stream.
// ----------------------------------------------------------------------------
module tile_dirty_rectangle_detector_unit_tb;
    import tdrd_pkg::*;

    // Indexes past the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 4;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Predictor state: tile size registers and the box being gathered.
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [POS_W-1:0] scan_col;
    logic [POS_W-1:0] scan_row;
    logic             tile_dirty;
    logic [POS_W-1:0] dirty_left;
    logic [POS_W-1:0] dirty_right;
    logic [POS_W-1:0] dirty_top;
    logic [POS_W-1:0] dirty_bottom;

    tile_box_t pending_boxes[$];

    int  errors;
    int  words_sent;
    int  boxes_checked;
    bit  gaps_on;
    bit  stalls_on;
    bit  hold_off_req;

    tile_dirty_rectangle_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock, period 2 ns.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Zero counts as one, and sizes above the maximum saturate.
    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > MAX_TILE_DIM) begin
            return MAX_TILE_DIM;
        end
        return int'(v);
    endfunction

    // Advance the predicted scan by one word and queue a box at tile end.
    task automatic track_word(input logic [31:0] nw, input logic [31:0] ow);
        int        w;
        int        h;
        bit        row_end;
        bit        tile_end;
        tile_box_t box;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        row_end  = (int'(scan_col) + 1 >= w);
        tile_end = row_end && (int'(scan_row) + 1 >= h);
        if (nw != ow) begin
            if (!tile_dirty) begin
                tile_dirty  = 1'b1;
                dirty_left  = scan_col;
                dirty_right = scan_col;
                dirty_top   = scan_row;
            end else begin
                if (scan_col < dirty_left) dirty_left = scan_col;
                if (scan_col > dirty_right) dirty_right = scan_col;
            end
            dirty_bottom = scan_row;
        end
        if (tile_end) begin
            box = '0;
            if (tile_dirty) begin
                box.changed = 1'b1;
                box.left    = dirty_left;
                box.top     = dirty_top;
                box.right   = dirty_right;
                box.bottom  = dirty_bottom;
            end
            pending_boxes.push_back(box);
            scan_col     = '0;
            scan_row     = '0;
            tile_dirty   = 1'b0;
            dirty_left   = '0;
            dirty_right  = '0;
            dirty_top    = '0;
            dirty_bottom = '0;
        end else if (row_end) begin
            scan_col = '0;
            scan_row = scan_row + POS_W'(1);
        end else begin
            scan_col = scan_col + POS_W'(1);
        end
    endtask

    // Offer one word pair; called and left at a falling edge.
    task automatic send_pair(input logic [31:0] nw, input logic [31:0] ow);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ow, nw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_word(nw, ow);
        words_sent++;
        @(negedge aclk);
    endtask

    // Stop requests and wait until every queued box has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_boxes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TILE_WIDTH) begin
            width_reg = val;
        end else if (idx == REG_TILE_HEIGHT) begin
            height_reg = val;
        end
        @(negedge aclk);
    endtask

    // One setting: drain, resize, then stream words with a given share of
    // differing pairs (single-bit flips or unrelated words).
    task automatic run_phase(input logic [DIM_W-1:0] w_val, input logic [DIM_W-1:0] h_val,
                             input int words, input int diff_pct);
        logic [31:0] nw;
        logic [31:0] ow;
        int          r;
        drain();
        write_reg(REG_TILE_WIDTH, w_val);
        write_reg(REG_TILE_HEIGHT, h_val);
        repeat (words) begin
            nw = $urandom();
            r  = $urandom_range(0, 99);
            if (r >= diff_pct) begin
                ow = nw;
            end else if (r[0]) begin
                ow = nw ^ (32'h1 << $urandom_range(0, 31));
            end else begin
                ow = $urandom();
            end
            send_pair(nw, ow);
        end
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 11);
        case (r)
            0: return '0;
            1: return DIM_W'(MAX_TILE_DIM);
            2: return DIM_W'($urandom_range(MAX_TILE_DIM + 1, 127));
            3: return DIM_W'($urandom_range(9, MAX_TILE_DIM - 1));
            default: return DIM_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Reset sizes with a shrink in mid tile, the size clamps, word extremes
    // and writes to indexes past the register list.
    task automatic test_directed_corners();
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h1234_5678, 32'h1234_5678);
        send_pair(32'hA5A5_A5A5, 32'hA5A5_A5A5);
        send_pair(32'h8000_0000, 32'h0000_0000);
        drain();
        // Column 5 is past the new width, so this word closes row 0.
        write_reg(REG_TILE_WIDTH, 7'd3);
        write_reg(REG_TILE_HEIGHT, 7'd2);
        send_pair(32'h5A5A_5A5A, 32'h5A5A_5A5A);
        send_pair(32'h0000_0001, 32'h0000_0000);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0F0F_0F0F, 32'h0F0F_0F0F);
        drain();
        // Zero sizes act as a one-word tile.
        write_reg(REG_TILE_WIDTH, 7'd0);
        write_reg(REG_TILE_HEIGHT, 7'd0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_SPARE_A, 7'd5);
        write_reg(REG_SPARE_B, 7'd127);
        send_pair(32'hDEAD_BEEF, 32'hDEAD_BEEF);
        send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_tiles(input int budget);
        logic [DIM_W-1:0] a;
        logic [DIM_W-1:0] b;
        int               area;
        int               words;
        int               pct;
        int               stop_at;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            a = pick_dim();
            b = (clamp_dim(a) > 8) ? DIM_W'($urandom_range(0, 3)) : pick_dim();
            if ($urandom_range(0, 1) == 1) begin
                a = a ^ b;
                b = a ^ b;
                a = a ^ b;
            end
            area  = clamp_dim(a) * clamp_dim(b);
            words = area * ((area > 32) ? 1 : $urandom_range(1, 4));
            // Sometimes leave a tile unfinished so the next size lands mid tile.
            if ($urandom_range(0, 3) == 0) words += $urandom_range(1, area);
            case ($urandom_range(0, 9))
                0: pct = 0;
                1: pct = 100;
                2, 3, 4, 5: pct = 3;
                default: pct = 20;
            endcase
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            run_phase(a, b, words, pct);
        end
    endtask

    // One-word tiles while the receiver holds off, so the result buffer
    // fills and the input stalls.
    task automatic test_output_backpressure();
        drain();
        hold_off_req = 1'b1;
        gaps_on = 1'b0;
        run_phase(7'd1, 7'd1, 40, 30);
    endtask

    task automatic test_steady_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_phase(7'd4, 7'd4, 64, 20);
        run_phase(7'd64, 7'd2, 128, 3);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each delivered box with the oldest prediction.
    always @(posedge aclk) begin : box_check
        tile_box_t want;
        tile_box_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[BOX_W-1:0];
            if (pending_boxes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_boxes.pop_front();
                boxes_checked++;
                check_field("changed", 32'(want.changed), 32'(got.changed));
                check_field("box_left", 32'(want.left), 32'(got.left));
                check_field("box_top", 32'(want.top), 32'(got.top));
                check_field("box_right", 32'(want.right), 32'(got.right));
                check_field("box_bottom", 32'(want.bottom), 32'(got.bottom));
                check_field("padding", 32'(0), 32'(m_tdata[OUT_TDATA_W-1:BOX_W]));
            end
        end
    end

    initial begin : main_seq
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        width_reg    = DIM_W'(TILE_DIM_RST);
        height_reg   = DIM_W'(TILE_DIM_RST);
        scan_col     = '0;
        scan_row     = '0;
        tile_dirty   = 1'b0;
        dirty_left   = '0;
        dirty_right  = '0;
        dirty_top    = '0;
        dirty_bottom = '0;
        errors        = 0;
        words_sent    = 0;
        boxes_checked = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        hold_off_req  = 1'b0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_corners();
        test_random_tiles(500);
        test_output_backpressure();
        test_random_tiles(500);
        test_steady_stream();
        drain();
        repeat (8) @(negedge aclk);

        $display("Run summary: %0d word pairs streamed, %0d tile boxes compared.",
                 words_sent, boxes_checked);
        $display("Sizes 1..64 with zero and oversize writes, mid-tile resizing, hold-off.");
        if (errors == 0 && pending_boxes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tdrd_pkg.sv
rtl/tdrd_cfg.sv
rtl/tdrd_tracker.sv
rtl/tdrd_out_fifo.sv
rtl/tile_dirty_rectangle_detector_unit.sv
tb/tile_dirty_rectangle_detector_unit_tb.sv
